FILE: rtl/midpoint_circle_rasterizer_top_assert.svh
// assertion macros shared by the checker
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication under reset
`define MCR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("mcr check failed");

// next-cycle implication under reset
`define MCR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("mcr check failed");

`endif

FILE: rtl/mcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

	// radius precision and derived widths
	localparam int RADIUS_BITS = 11;
	localparam int OFS_W       = RADIUS_BITS + 1;
	localparam int DEC_W       = RADIUS_BITS + 5;
	localparam int CX_W        = 13;
	localparam int CRD_W       = 14;
	localparam int ARITH_W     = ((CX_W > OFS_W) ? CX_W : OFS_W) + 1;

	// opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// decision constants
	localparam int DEC_INIT   = 3;
	localparam int DEC_INC_LO = 6;
	localparam int DEC_INC_HI = 10;

	// result sequencing
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] IDX_LAST_FILL = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_LAST_LINE = IDX_W'(7);

	// step queue
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	// one step worth of work for the emitter
	typedef struct packed {
		logic signed [CX_W-1:0]  cx;
		logic signed [CX_W-1:0]  cy;
		logic [RADIUS_BITS-1:0]  ox;
		logic [RADIUS_BITS-1:0]  oy;
		logic                    fill;
		logic                    last;
	} job_t;

endpackage

`default_nettype wire

FILE: rtl/midpoint_circle_rasterizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Midpoint circle rasterizer. A start request (opcode 0) loads center, radius
// and mode and produces nothing; each step request (opcode 1) produces eight
// outline points or four fill spans, flagged with end_of_step on the last one
// and end_of_circle on the last one of the circle. Results leave at one per
// cycle while out_ready holds, eight per step in outline mode and four in fill
// mode; that emitter is the bottleneck. The input side runs the midpoint
// update in the cycle a step is taken and parks the step in a two-entry
// queue, so up to three steps can be accepted ahead of the results still
// draining. A start restarts at once; steps already queued still emit their
// results. Steps while no circle is active are dropped.
module midpoint_circle_rasterizer_top import mcr_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    opcode,
	input  wire logic signed [CX_W-1:0]  center_x,
	input  wire logic signed [CX_W-1:0]  center_y,
	input  wire logic [RADIUS_BITS-1:0]  radius,
	input  wire logic                    fill_mode,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [CRD_W-1:0]      x_start,
	output logic signed [CRD_W-1:0]      x_end,
	output logic signed [CRD_W-1:0]      row_y,
	output logic                         end_of_step,
	output logic                         end_of_circle
);

	logic push;
	job_t push_job;
	logic queue_full;
	logic pop;
	logic head_valid;
	job_t head_job;

	// request intake and circle state
	mcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.fill_mode  (fill_mode),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	// step queue
	mcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// result emitter
	mcr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.x_start       (x_start),
		.x_end         (x_end),
		.row_y         (row_y),
		.end_of_step   (end_of_step),
		.end_of_circle (end_of_circle)
	);

endmodule

`default_nettype wire

FILE: rtl/mcr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mcr_front import mcr_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   opcode,
	input  wire logic signed [CX_W-1:0] center_x,
	input  wire logic signed [CX_W-1:0] center_y,
	input  wire logic [RADIUS_BITS-1:0] radius,
	input  wire logic                   fill_mode,
	input  wire logic                   queue_full,
	output logic                        push,
	output job_t                        push_job
);

	logic                          active_q;
	logic [RADIUS_BITS-1:0]        ox_q;
	logic signed [OFS_W-1:0]       oy_q;
	logic signed [DEC_W-1:0]       dec_q;
	logic signed [CX_W-1:0]        cx_q;
	logic signed [CX_W-1:0]        cy_q;
	logic                          fill_q;

	logic                          accept;
	logic [RADIUS_BITS-1:0]        ox_next;
	logic signed [OFS_W-1:0]       oy_next;
	logic signed [DEC_W-1:0]       dec_next;
	logic [DEC_W-1:0]              ox4;
	logic [DEC_W-1:0]              oy4;
	logic                          done;

	// request handshake
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (opcode == OP_STEP) && active_q;

	// one midpoint iteration
	assign ox4     = DEC_W'({ox_q, 2'b00});
	assign oy4     = DEC_W'({oy_q[RADIUS_BITS-1:0], 2'b00});
	assign ox_next = ox_q + RADIUS_BITS'(1);
	always_comb begin
		if (dec_q[DEC_W-1]) begin
			dec_next = dec_q + ox4 + DEC_W'(DEC_INC_LO);
			oy_next  = oy_q;
		end else begin
			dec_next = dec_q + ox4 - oy4 + DEC_W'(DEC_INC_HI);
			oy_next  = oy_q - OFS_W'(1);
		end
	end
	assign done = oy_next < $signed({1'b0, ox_next});

	// job snapshot taken before the update
	always_comb begin
		push_job.cx   = cx_q;
		push_job.cy   = cy_q;
		push_job.ox   = ox_q;
		push_job.oy   = oy_q[RADIUS_BITS-1:0];
		push_job.fill = fill_q;
		push_job.last = done;
	end

	// circle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			fill_q   <= 1'b0;
		end else if (accept && (opcode == OP_START)) begin
			active_q <= 1'b1;
			ox_q     <= '0;
			oy_q     <= OFS_W'(radius);
			dec_q    <= DEC_W'(DEC_INIT) - DEC_W'({radius, 1'b0});
			cx_q     <= center_x;
			cy_q     <= center_y;
			fill_q   <= fill_mode;
		end else if (push) begin
			active_q <= !done;
			ox_q     <= ox_next;
			oy_q     <= oy_next;
			dec_q    <= dec_next;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mcr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mcr_queue import mcr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	job_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full       = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mcr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mcr_back import mcr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 head_valid,
	input  job_t                      head_job,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [CRD_W-1:0]   x_start,
	output logic signed [CRD_W-1:0]   x_end,
	output logic signed [CRD_W-1:0]   row_y,
	output logic                      end_of_step,
	output logic                      end_of_circle
);

	job_t                    job_q;
	logic                    job_valid_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    out_valid_q;
	logic signed [CRD_W-1:0] xs_q;
	logic signed [CRD_W-1:0] xe_q;
	logic signed [CRD_W-1:0] row_q;
	logic                    eos_q;
	logic                    eoc_q;

	logic                    adv;
	logic                    last_k;
	logic                    job_done;
	logic                    swap;
	logic                    neg_row;
	logic [RADIUS_BITS-1:0]  a;
	logic [RADIUS_BITS-1:0]  b;
	logic [ARITH_W-1:0]      cx_e;
	logic [ARITH_W-1:0]      cy_e;
	logic [ARITH_W-1:0]      x_plus;
	logic [ARITH_W-1:0]      x_minus;
	logic [ARITH_W-1:0]      row_v;
	logic [CRD_W-1:0]        xs_v;
	logic [CRD_W-1:0]        xe_v;

	// sequencing control
	assign adv      = job_valid_q && (!out_valid_q || out_ready);
	assign last_k   = idx_q == (job_q.fill ? IDX_LAST_FILL : IDX_LAST_LINE);
	assign job_done = adv && last_k;
	assign pop      = head_valid && (!job_valid_q || job_done);

	// pick offsets and signs for the current result
	assign swap    = job_q.fill ? idx_q[1] : idx_q[2];
	assign neg_row = job_q.fill ? idx_q[0] : idx_q[1];
	assign a       = swap ? job_q.oy : job_q.ox;
	assign b       = swap ? job_q.ox : job_q.oy;

	// coordinate arithmetic, wraps to the output width
	assign cx_e    = {{(ARITH_W-CX_W){job_q.cx[CX_W-1]}}, job_q.cx};
	assign cy_e    = {{(ARITH_W-CX_W){job_q.cy[CX_W-1]}}, job_q.cy};
	assign x_plus  = cx_e + ARITH_W'(a);
	assign x_minus = cx_e - ARITH_W'(a);
	assign row_v   = neg_row ? (cy_e - ARITH_W'(b)) : (cy_e + ARITH_W'(b));
	assign xs_v    = (job_q.fill || idx_q[0]) ? x_minus[CRD_W-1:0] : x_plus[CRD_W-1:0];
	assign xe_v    = (!job_q.fill && idx_q[0]) ? x_minus[CRD_W-1:0] : x_plus[CRD_W-1:0];

	// current job and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			job_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (job_done) begin
			job_valid_q <= 1'b0;
		end else if (adv) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xs_q  <= $signed(xs_v);
			xe_q  <= $signed(xe_v);
			row_q <= $signed(row_v[CRD_W-1:0]);
			eos_q <= last_k;
			eoc_q <= last_k && job_q.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign x_start       = xs_q;
	assign x_end         = xe_q;
	assign row_y         = row_q;
	assign end_of_step   = eos_q;
	assign end_of_circle = eoc_q;

endmodule

`default_nettype wire

FILE: rtl/mcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "midpoint_circle_rasterizer_top_assert.svh"

module mcr_checker import mcr_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [CRD_W-1:0] x_start,
	input wire logic signed [CRD_W-1:0] x_end,
	input wire logic signed [CRD_W-1:0] row_y,
	input wire logic                    end_of_step,
	input wire logic                    end_of_circle
);

	// circle end only closes a step
	`MCR_ASSERT_NOW(a_eoc_in_step, clk, arst_n, out_valid && end_of_circle, end_of_step)

	// spans never run backwards
	`MCR_ASSERT_NOW(a_span_order, clk, arst_n, out_valid, x_start <= x_end)

	// a step's results come out back to back
	`MCR_ASSERT_NEXT(a_step_burst, clk, arst_n, out_valid && out_ready && !end_of_step,
		out_valid)

	// stalled result holds
	`MCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(x_start) && $stable(x_end) && $stable(row_y))

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (.*);

`default_nettype wire

FILE: verif/mcr_span_checker.sv
`timescale 1ns / 1ps

module mcr_span_checker import mcr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic                    opcode,
	input  logic signed [CX_W-1:0]  center_x,
	input  logic signed [CX_W-1:0]  center_y,
	input  logic [RADIUS_BITS-1:0]  radius,
	input  logic                    fill_mode,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [CRD_W-1:0] x_start,
	input  logic signed [CRD_W-1:0] x_end,
	input  logic signed [CRD_W-1:0] row_y,
	input  logic                    end_of_step,
	input  logic                    end_of_circle,
	input  logic                    wrap_up,
	output int                      fail_count,
	output int                      spans_owed,
	output logic                    circle_open
);

	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic signed [CRD_W-1:0] xs;
		logic signed [CRD_W-1:0] xe;
		logic signed [CRD_W-1:0] row;
		logic                    step_last;
		logic                    circle_last;
	} span_t;

	// spans still owed by the block, oldest first
	span_t pending_spans[$];

	// private copy of the circle being traced
	logic signed [CX_W-1:0]  ctr_x;
	logic signed [CX_W-1:0]  ctr_y;
	logic signed [OFS_W-1:0] ofs_x;
	logic signed [OFS_W-1:0] ofs_y;
	logic signed [DEC_W-1:0] decision;
	logic                    fill_on;
	logic                    wrapped;

	initial begin
		fail_count = 0;
		spans_owed = 0;
		circle_open = 1'b0;
		wrapped = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < MAX_PRINTED)
			$display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	// coordinates wrap to the output width
	function automatic span_t make_span(input int xs, input int xe, input int row);
		span_t s;
		s.xs = CRD_W'(xs);
		s.xe = CRD_W'(xe);
		s.row = CRD_W'(row);
		s.step_last = 1'b0;
		s.circle_last = 1'b0;
		return s;
	endfunction

	// one midpoint iteration: queue its spans, then advance the offsets
	task automatic rasterize_step();
		span_t burst[8];
		int cx;
		int cy;
		int ox;
		int oy;
		int n;
		cx = int'(ctr_x);
		cy = int'(ctr_y);
		ox = int'(ofs_x);
		oy = int'(ofs_y);
		if (fill_on) begin
			burst[0] = make_span(cx - ox, cx + ox, cy + oy);
			burst[1] = make_span(cx - ox, cx + ox, cy - oy);
			burst[2] = make_span(cx - oy, cx + oy, cy + ox);
			burst[3] = make_span(cx - oy, cx + oy, cy - ox);
			n = 4;
		end else begin
			burst[0] = make_span(cx + ox, cx + ox, cy + oy);
			burst[1] = make_span(cx - ox, cx - ox, cy + oy);
			burst[2] = make_span(cx + ox, cx + ox, cy - oy);
			burst[3] = make_span(cx - ox, cx - ox, cy - oy);
			burst[4] = make_span(cx + oy, cx + oy, cy + ox);
			burst[5] = make_span(cx - oy, cx - oy, cy + ox);
			burst[6] = make_span(cx + oy, cx + oy, cy - ox);
			burst[7] = make_span(cx - oy, cx - oy, cy - ox);
			n = 8;
		end
		if (decision < 0) begin
			decision = DEC_W'(int'(decision) + 4 * ox + DEC_INC_LO);
		end else begin
			decision = DEC_W'(int'(decision) + 4 * (ox - oy) + DEC_INC_HI);
			ofs_y = ofs_y - 1;
		end
		ofs_x = ofs_x + 1;
		if (ofs_y < ofs_x)
			circle_open = 1'b0;
		burst[n-1].step_last = 1'b1;
		burst[n-1].circle_last = !circle_open;
		for (int i = 0; i < n; i++)
			pending_spans.push_back(burst[i]);
	endtask

	task automatic check_span(input span_t want);
		if (x_start !== want.xs)
			report_mismatch("x_start", x_start, want.xs);
		if (x_end !== want.xe)
			report_mismatch("x_end", x_end, want.xe);
		if (row_y !== want.row)
			report_mismatch("row_y", row_y, want.row);
		if (end_of_step !== want.step_last)
			report_mismatch("end_of_step", end_of_step, want.step_last);
		if (end_of_circle !== want.circle_last)
			report_mismatch("end_of_circle", end_of_circle, want.circle_last);
	endtask

	// predict on each accepted request, compare each accepted span
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_spans.delete();
			spans_owed = 0;
			circle_open = 1'b0;
			ofs_x = '0;
			ofs_y = '0;
			decision = '0;
			ctr_x = '0;
			ctr_y = '0;
			fill_on = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (opcode == OP_START) begin
					ctr_x = center_x;
					ctr_y = center_y;
					fill_on = fill_mode;
					ofs_x = '0;
					ofs_y = OFS_W'(radius);
					decision = DEC_W'(DEC_INIT - 2 * int'(radius));
					circle_open = 1'b1;
				end else if (circle_open) begin
					rasterize_step();
				end
			end
			if (out_valid && out_ready) begin
				if (pending_spans.size() == 0)
					report_mismatch("span with nothing expected, x_start", x_start, 0);
				else
					check_span(pending_spans.pop_front());
			end
			spans_owed = pending_spans.size();
			// spans that never showed up
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (spans_owed != 0)
					report_mismatch("spans never produced, count", spans_owed, 0);
			end
		end
	end

endmodule

FILE: verif/midpoint_circle_rasterizer_top_tb.sv
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_top_tb import mcr_pkg::*; ();

	localparam int ITEM_TARGET = 420;
	localparam int PRESSURE_AT = 150;
	localparam int HOLD_CYCLES = 160;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 32;
	localparam int NO_CAP      = 1 << 30;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    opcode;
	logic signed [CX_W-1:0]  center_x;
	logic signed [CX_W-1:0]  center_y;
	logic [RADIUS_BITS-1:0]  radius;
	logic                    fill_mode;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [CRD_W-1:0] x_start;
	logic signed [CRD_W-1:0] x_end;
	logic signed [CRD_W-1:0] row_y;
	logic                    end_of_step;
	logic                    end_of_circle;

	logic wrap_up;
	int   fail_count;
	int   spans_owed;
	logic circle_open;

	int hold_asks;
	int burst_left;
	int requests_counted;
	int quiet_cycles;

	midpoint_circle_rasterizer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius        (radius),
		.fill_mode     (fill_mode),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.x_start       (x_start),
		.x_end         (x_end),
		.row_y         (row_y),
		.end_of_step   (end_of_step),
		.end_of_circle (end_of_circle)
	);

	mcr_span_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius        (radius),
		.fill_mode     (fill_mode),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.x_start       (x_start),
		.x_end         (x_end),
		.row_y         (row_y),
		.end_of_step   (end_of_step),
		.end_of_circle (end_of_circle),
		.wrap_up       (wrap_up),
		.fail_count    (fail_count),
		.spans_owed    (spans_owed),
		.circle_open   (circle_open)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int rand_coord();
		return int'($urandom_range(0, 8191)) - 4096;
	endfunction

	// bursts of back-to-back requests separated by idle gaps; called at a falling edge
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				center_x = CX_W'($urandom);
				center_y = CX_W'($urandom);
				radius = RADIUS_BITS'($urandom);
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
		end
		burst_left--;
	endtask

	// offer one request and hold it until taken; returns at a falling edge
	task automatic send_request(input logic op, input int cx, input int cy, input int r,
			input logic fm);
		pace_sender();
		if (op == OP_START || circle_open)
			requests_counted++;
		in_valid = 1'b1;
		opcode = op;
		center_x = CX_W'(cx);
		center_y = CX_W'(cy);
		radius = RADIUS_BITS'(r);
		fill_mode = fm;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// step with junk in the fields a step ignores
	task automatic send_step();
		send_request(OP_STEP, rand_coord(), rand_coord(), $urandom_range(0, 2047),
			1'($urandom_range(0, 1)));
	endtask

	// start a circle, then step it until it closes or the cap is hit
	task automatic run_circle(input int r, input logic fm, input int step_cap,
			input bit extra, input bit squeeze);
		int taken;
		send_request(OP_START, rand_coord(), rand_coord(), r, fm);
		if (squeeze)
			hold_asks++;
		taken = 0;
		while (circle_open && taken < step_cap) begin
			send_step();
			taken++;
		end
		if (extra)
			send_step();
	endtask

	// receiver: changing stall patterns, plus one long hold on request
	initial begin
		int mode;
		int phase_left;
		int holds_served;
		out_ready = 1'b0;
		mode = 0;
		phase_left = 0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_asks != holds_served) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 80);
			end
			phase_left--;
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = ~out_ready;
				2: out_ready = 1'($urandom_range(0, 1));
				default: out_ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// watchdog on cycles with no request or span moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("midpoint_circle_rasterizer_top verification failed");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int kind;
		int r;
		int cap;
		int drain;
		bit pressure_done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_START;
		center_x = '0;
		center_y = '0;
		radius = '0;
		fill_mode = 1'b0;
		wrap_up = 1'b0;
		hold_asks = 0;
		burst_left = 0;
		requests_counted = 0;
		pressure_done = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// step with no circle loaded
		send_step();
		// zero radius in both modes, extreme centers, step after the circle closed
		send_request(OP_START, 0, 0, 0, 1'b0);
		send_step();
		send_step();
		send_request(OP_START, -4096, 4095, 0, 1'b1);
		send_step();
		// largest radius at the corners, restarted mid-circle
		send_request(OP_START, 4095, -4096, 2047, 1'b0);
		send_step();
		send_step();
		send_request(OP_START, -4096, -4096, 2047, 1'b1);
		send_step();
		send_step();
		// small full circle with a trailing step
		send_request(OP_START, -1, 1, 5, 1'b0);
		repeat (5) send_step();
		// alternating radius and center bit patterns
		send_request(OP_START, -1366, 2730, 1365, 1'b1);
		send_step();
		send_request(OP_START, 2730, -1366, 682, 1'b0);
		send_step();

		// random circles, mostly complete, some cut short or with noise around them
		while (requests_counted < ITEM_TARGET) begin
			kind = $urandom_range(0, 15);
			if (!pressure_done && requests_counted >= PRESSURE_AT) begin
				run_circle(80, 1'b0, NO_CAP, 1'b0, 1'b1);
				pressure_done = 1'b1;
			end else if (kind == 0) begin
				send_step();
			end else if (kind == 1) begin
				send_request(OP_START, rand_coord(), rand_coord(), $urandom_range(0, 2047),
					1'($urandom_range(0, 1)));
			end else begin
				if (kind == 2)
					r = $urandom_range(0, 2047);
				else if (kind < 5)
					r = $urandom_range(25, 120);
				else
					r = $urandom_range(0, 24);
				cap = (kind == 2 || $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : NO_CAP;
				run_circle(r, 1'($urandom_range(0, 1)), cap, $urandom_range(0, 7) == 0, 1'b0);
			end
		end
		in_valid = 1'b0;

		// let the owed spans drain, then watch for strays
		drain = 0;
		while (spans_owed != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		wrap_up = 1'b1;
		@(negedge clk);
		if (fail_count == 0 && spans_owed == 0)
			$display("midpoint_circle_rasterizer_top verification clean");
		else
			$display("midpoint_circle_rasterizer_top verification failed");
		$finish;
	end

endmodule
